[hw/rtl/ryc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryc_pkg
// Shared types and constants of the RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
package ryc_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [CFG_DATA_W-1:0] DIM_MIN          = 12'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // Color matrix, signed 18-bit coefficients with 16 fraction bits
    localparam logic signed [17:0] Y_B  = 18'sd6416;
    localparam logic signed [17:0] Y_G  = 18'sd33039;
    localparam logic signed [17:0] Y_R  = 18'sd16829;
    localparam logic signed [17:0] CB_B = 18'sd28784;
    localparam logic signed [17:0] CB_G = -18'sd19070;
    localparam logic signed [17:0] CB_R = -18'sd9714;
    localparam logic signed [17:0] CR_B = -18'sd4681;
    localparam logic signed [17:0] CR_G = -18'sd24103;
    localparam logic signed [17:0] CR_R = 18'sd28784;

    localparam logic signed [25:0] ACC_ROUND = 26'sd32768;
    localparam logic [7:0]         Y_OFFSET  = 8'd16;
    localparam logic [7:0]         C_OFFSET  = 8'd128;

    typedef struct packed {
        logic valid;
        logic col_odd;
        logic row_odd;
        logic last;
    } ryc_ctrl_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
    } ryc_color_t;

endpackage

[hw/rtl/ryc_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryc_ifs
// Pixel, result and register write channels of the converter.
// ----------------------------------------------------------------------------
interface ryc_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink (input valid, input blue, input green, input red, output ready);
endinterface

interface ryc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic       frame_end;

    modport source (
        output valid, output luma, output chroma_valid, output blue_diff,
        output red_diff, output frame_end, input ready
    );
    modport sink (
        input valid, input luma, input chroma_valid, input blue_diff,
        input red_diff, input frame_end, output ready
    );
endinterface

interface ryc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/ryc_csc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryc_csc
// Color matrix stage: luma, Cb and Cr of one pixel into a pipeline register.
// ----------------------------------------------------------------------------
module ryc_csc #(
    parameter int ADDR_W = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  ryc_pkg::ryc_ctrl_t  ctrl,
    input  logic [ADDR_W-1:0]   slot,
    input  logic [7:0]          blue,
    input  logic [7:0]          green,
    input  logic [7:0]          red,
    output ryc_pkg::ryc_ctrl_t  ctrl_out,
    output logic [ADDR_W-1:0]   slot_out,
    output ryc_pkg::ryc_color_t color_out
);
    import ryc_pkg::*;

    logic signed [8:0]  b_s;
    logic signed [8:0]  g_s;
    logic signed [8:0]  r_s;
    logic signed [25:0] y_acc;
    logic signed [25:0] cb_acc;
    logic signed [25:0] cr_acc;
    ryc_color_t         color_next;
    ryc_ctrl_t          ctrl_reg;
    logic [ADDR_W-1:0]  slot_reg;
    ryc_color_t         color_reg;

    always_comb
    begin
        b_s    = $signed({1'b0, blue});
        g_s    = $signed({1'b0, green});
        r_s    = $signed({1'b0, red});
        y_acc  = ACC_ROUND + Y_B * b_s + Y_G * g_s + Y_R * r_s;
        cb_acc = ACC_ROUND + CB_B * b_s + CB_G * g_s + CB_R * r_s;
        cr_acc = ACC_ROUND + CR_B * b_s + CR_G * g_s + CR_R * r_s;
        // floor shift by 16, then offset, modulo 256
        color_next.luma = 8'(y_acc[25:16]) + Y_OFFSET;
        color_next.cb   = 8'(cb_acc[25:16]) + C_OFFSET;
        color_next.cr   = 8'(cr_acc[25:16]) + C_OFFSET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && ctrl.valid)
        begin
            slot_reg  <= slot;
            color_reg <= color_next;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign slot_out  = slot_reg;
    assign color_out = color_reg;

endmodule

[hw/rtl/ryc_chroma.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryc_chroma
// Horizontal pair sums, line buffer of pair sums, 2x2 average and result
// register.
// ----------------------------------------------------------------------------
module ryc_chroma #(
    parameter int LINE_DEPTH = 1024,
    parameter int ADDR_W     = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_slot,
    input  logic                en,
    input  ryc_pkg::ryc_ctrl_t  ctrl,
    input  logic [ADDR_W-1:0]   slot,
    input  ryc_pkg::ryc_color_t color,
    output logic                out_valid,
    output logic [7:0]          out_luma,
    output logic                out_chroma_valid,
    output logic [7:0]          out_blue_diff,
    output logic [7:0]          out_red_diff,
    output logic                out_frame_end
);
    import ryc_pkg::*;

    logic [17:0] line_mem [LINE_DEPTH];
    logic [17:0] line_rd_reg;
    logic [8:0]  pair_cb_reg;
    logic [8:0]  pair_cr_reg;
    logic [8:0]  pair_cb_next;
    logic [8:0]  pair_cr_next;
    logic [9:0]  quad_cb;
    logic [9:0]  quad_cr;
    logic        emit;
    logic        store;
    logic        out_valid_reg;
    logic [7:0]  luma_reg;
    logic        chroma_valid_reg;
    logic [7:0]  blue_diff_reg;
    logic [7:0]  red_diff_reg;
    logic        frame_end_reg;

    always_comb
    begin
        if (ctrl.col_odd)
        begin
            pair_cb_next = pair_cb_reg + {1'b0, color.cb};
            pair_cr_next = pair_cr_reg + {1'b0, color.cr};
        end
        else
        begin
            pair_cb_next = {1'b0, color.cb};
            pair_cr_next = {1'b0, color.cr};
        end
        quad_cb = 10'd2 + {1'b0, pair_cb_next} + {1'b0, line_rd_reg[8:0]};
        quad_cr = 10'd2 + {1'b0, pair_cr_next} + {1'b0, line_rd_reg[17:9]};
        emit    = ctrl.col_odd && ctrl.row_odd;
        store   = ctrl.col_odd && !ctrl.row_odd;
    end

    // line buffer: cb pair sum low, cr pair sum high
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            line_rd_reg <= line_mem[rd_slot];
        end
        if (en && ctrl.valid && store)
        begin
            line_mem[slot] <= {pair_cr_next, pair_cb_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_cb_reg   <= '0;
            pair_cr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctrl.valid;
            if (ctrl.valid)
            begin
                pair_cb_reg <= pair_cb_next;
                pair_cr_reg <= pair_cr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && ctrl.valid)
        begin
            luma_reg         <= color.luma;
            chroma_valid_reg <= emit;
            blue_diff_reg    <= emit ? quad_cb[9:2] : 8'd0;
            red_diff_reg     <= emit ? quad_cr[9:2] : 8'd0;
            frame_end_reg    <= ctrl.last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_luma         = luma_reg;
    assign out_chroma_valid = chroma_valid_reg;
    assign out_blue_diff    = blue_diff_reg;
    assign out_red_diff     = red_diff_reg;
    assign out_frame_end    = frame_end_reg;

endmodule

[hw/rtl/rgb_to_ycbcr420_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_ycbcr420_converter
// Rec.601 RGB to YCbCr 4:2:0 with luma and 2x2-averaged chroma interleaved
// in one result stream, one result per pixel.
//
//   channel  | dir | payload
//   ---------+-----+-------------------------------------------------
//   pixel    | in  | blue, green, red
//   result   | out | luma, chroma_valid, blue_diff, red_diff, frame_end
//   cfg      | in  | index (0 frame_width, 1 frame_height), data
//
// One pixel per cycle while the result side is ready; a taken request passes
// the input register, color matrix register and result register in turn.
// Each stage holds its item only while the stage after it is full and
// stalled, so a stalled result side stops input after three requests.
// The line buffer is a single memory read as an item enters its write stage.
// Reset clears counters and pipeline valids; the line buffer needs no clear.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr420_converter #(
    parameter int MAX_WIDTH  = ryc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ryc_pkg::MAX_HEIGHT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ryc_pixel_if.sink    pixel,
    ryc_result_if.source result,
    ryc_cfg_if.sink      cfg
);
    import ryc_pkg::*;

    localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [WW-1:0]         width_eff;
    logic [HW-1:0]         height_eff;
    logic [CW-1:0]         col_reg;
    logic [CW-1:0]         col_next;
    logic [RW-1:0]         row_reg;
    logic [RW-1:0]         row_next;
    logic                  col_last;
    logic                  row_last;
    logic                  in_take;

    ryc_ctrl_t             s1_ctrl_reg;
    logic [AW-1:0]         s1_slot_reg;
    logic [7:0]            s1_blue_reg;
    logic [7:0]            s1_green_reg;
    logic [7:0]            s1_red_reg;
    ryc_ctrl_t             s1_ctrl_next;

    ryc_ctrl_t             s2_ctrl;
    logic [AW-1:0]         s2_slot;
    ryc_color_t            s2_color;

    logic                  out_valid;
    logic                  en1;
    logic                  en2;
    logic                  en3;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:  width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: height_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // clamp dimensions to 2..max
    always_comb
    begin
        if (width_reg < DIM_MIN)
            width_eff = WW'(2);
        else if (int'(width_reg) > MAX_WIDTH)
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(width_reg);

        if (height_reg < DIM_MIN)
            height_eff = HW'(2);
        else if (int'(height_reg) > MAX_HEIGHT)
            height_eff = HW'(MAX_HEIGHT);
        else
            height_eff = HW'(height_reg);
    end

    // pipeline flow
    assign en3         = !out_valid || result.ready;
    assign en2         = !s2_ctrl.valid || en3;
    assign en1         = !s1_ctrl_reg.valid || en2;
    assign pixel.ready = en1;
    assign in_take     = pixel.valid && en1;

    // raster position
    always_comb
    begin
        col_last = WW'(col_reg) >= (width_eff - WW'(1));
        row_last = HW'(row_reg) >= (height_eff - HW'(1));
        col_next = col_reg;
        row_next = row_reg;
        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
        s1_ctrl_next.valid   = pixel.valid;
        s1_ctrl_next.col_odd = col_reg[0];
        s1_ctrl_next.row_odd = row_reg[0];
        s1_ctrl_next.last    = col_last && row_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            s1_ctrl_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (en1)
            begin
                s1_ctrl_reg <= s1_ctrl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_slot_reg  <= AW'(col_reg >> 1);
            s1_blue_reg  <= pixel.blue;
            s1_green_reg <= pixel.green;
            s1_red_reg   <= pixel.red;
        end
    end

    ryc_csc #(
        .ADDR_W (AW)
    ) u_csc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en2),
        .ctrl      (s1_ctrl_reg),
        .slot      (s1_slot_reg),
        .blue      (s1_blue_reg),
        .green     (s1_green_reg),
        .red       (s1_red_reg),
        .ctrl_out  (s2_ctrl),
        .slot_out  (s2_slot),
        .color_out (s2_color)
    );

    ryc_chroma #(
        .LINE_DEPTH (LINE_DEPTH),
        .ADDR_W     (AW)
    ) u_chroma (
        .clk              (clk),
        .rst_n            (rst_n),
        .rd_en            (en2),
        .rd_slot          (s1_slot_reg),
        .en               (en3),
        .ctrl             (s2_ctrl),
        .slot             (s2_slot),
        .color            (s2_color),
        .out_valid        (out_valid),
        .out_luma         (result.luma),
        .out_chroma_valid (result.chroma_valid),
        .out_blue_diff    (result.blue_diff),
        .out_red_diff     (result.red_diff),
        .out_frame_end    (result.frame_end)
    );

    assign result.valid = out_valid;

`ifndef SYNTHESIS
    // full and stalled pipeline takes no request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result.ready && s2_ctrl.valid && s1_ctrl_reg.valid) |-> !pixel.ready)
        else $error("request taken into a full stalled pipeline");

    // last pixel of the frame returns the raster to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && col_last && row_last) |=> (col_reg == '0 && row_reg == '0))
        else $error("raster position not reset after last pixel");

    // a delivered result with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result.ready && !s2_ctrl.valid) |=> !out_valid)
        else $error("result repeated");

    // chroma is only flagged on odd column and odd row
    assert property (@(posedge clk) disable iff (!rst_n)
        (en3 && s2_ctrl.valid && !(s2_ctrl.col_odd && s2_ctrl.row_odd))
            |=> !result.chroma_valid)
        else $error("chroma flagged outside a completed 2x2 block");
`endif

endmodule
